@@ rtl/slhp_pkg.sv @@
package slhp_pkg;

  // skip map geometry: one bit per dword of the segment, packed into rows
  localparam int SEG_WORDS = 16384;
  localparam int IDX_W     = $clog2(SEG_WORDS);
  localparam int ROW_BITS  = 32;
  localparam int SEL_W     = $clog2(ROW_BITS);
  localparam int ROWS      = SEG_WORDS / ROW_BITS;
  localparam int ROW_W     = $clog2(ROWS);

  localparam int HASH_W    = 32;
  localparam int ADDR_W    = 16;

  // h * 131 + w, mod 2^32, as shifts and adds
  function automatic logic [HASH_W-1:0] mac131(input logic [HASH_W-1:0] h,
                                                input logic [HASH_W-1:0] w);
    return (h << 7) + (h << 1) + h + w;
  endfunction

  typedef struct packed {
    logic             mark_go;
    logic [IDX_W-1:0] mark_first;
    logic [IDX_W-1:0] mark_last;
    logic             look_go;
    logic [IDX_W-1:0] look_idx;
  } smap_cmd_t;

  typedef struct packed {
    logic busy;
    logic skip_bit;
  } smap_stat_t;

  typedef struct packed {
    logic              take;
    logic [HASH_W-1:0] word;
    logic              fin_go;
    logic              clear;
  } hcore_cmd_t;

  typedef struct packed {
    logic              fin_busy;
    logic [HASH_W-1:0] hash;
  } hcore_stat_t;

endpackage

@@ rtl/slhp_skip_map.sv @@
module slhp_skip_map (
  input  logic                 clk,
  input  logic                 rst,
  input  slhp_pkg::smap_cmd_t  cmd,
  output slhp_pkg::smap_stat_t stat
);

  localparam logic [1:0] M_CLEAR = 2'd0;
  localparam logic [1:0] M_IDLE  = 2'd1;
  localparam logic [1:0] M_RD    = 2'd2;
  localparam logic [1:0] M_WR    = 2'd3;

  logic [slhp_pkg::ROW_BITS-1:0] mem [slhp_pkg::ROWS];

  logic [1:0]                     mstate;
  logic [slhp_pkg::ROW_W-1:0]     row;
  logic [slhp_pkg::IDX_W-1:0]     first;
  logic [slhp_pkg::IDX_W-1:0]     last;
  logic [slhp_pkg::SEL_W-1:0]     sel;
  logic [slhp_pkg::ROW_BITS-1:0]  rdata;

  logic [slhp_pkg::ROW_W-1:0]     rd_row;
  logic                           wr_en;
  logic [slhp_pkg::ROW_BITS-1:0]  wr_data;
  logic [slhp_pkg::ROW_BITS-1:0]  mask;
  logic [slhp_pkg::SEL_W-1:0]     lo;
  logic [slhp_pkg::SEL_W-1:0]     hi;
  logic [slhp_pkg::ROW_W-1:0]     last_row;

  assign last_row = last[slhp_pkg::IDX_W-1:slhp_pkg::SEL_W];

  // bits of the current row that fall inside first..last
  always_comb begin
    lo = (row == first[slhp_pkg::IDX_W-1:slhp_pkg::SEL_W]) ?
         first[slhp_pkg::SEL_W-1:0] : '0;
    hi = (row == last_row) ? last[slhp_pkg::SEL_W-1:0] : '1;
    for (int b = 0; b < slhp_pkg::ROW_BITS; b++) begin
      mask[b] = (slhp_pkg::SEL_W'(b) >= lo) && (slhp_pkg::SEL_W'(b) <= hi);
    end
  end

  always_comb begin
    rd_row  = cmd.look_go ? cmd.look_idx[slhp_pkg::IDX_W-1:slhp_pkg::SEL_W] : row;
    wr_en   = (mstate == M_CLEAR) || (mstate == M_WR);
    wr_data = (mstate == M_WR) ? (rdata | mask) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row] <= wr_data;
    end
    rdata <= mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_CLEAR;
      row    <= '0;
    end else begin
      unique case (mstate)
        M_CLEAR: begin
          row <= row + 1'b1;
          if (row == slhp_pkg::ROW_W'(slhp_pkg::ROWS - 1)) begin
            mstate <= M_IDLE;
          end
        end
        M_IDLE: begin
          if (cmd.mark_go) begin
            row    <= cmd.mark_first[slhp_pkg::IDX_W-1:slhp_pkg::SEL_W];
            mstate <= M_RD;
          end
        end
        M_RD: begin
          mstate <= M_WR;
        end
        M_WR: begin
          if (row == last_row) begin
            mstate <= M_IDLE;
          end else begin
            row    <= row + 1'b1;
            mstate <= M_RD;
          end
        end
        default: mstate <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_go) begin
      first <= cmd.mark_first;
      last  <= cmd.mark_last;
    end
    if (cmd.look_go) begin
      sel <= cmd.look_idx[slhp_pkg::SEL_W-1:0];
    end
  end

  assign stat.busy     = (mstate != M_IDLE);
  assign stat.skip_bit = rdata[sel];

endmodule

@@ rtl/slhp_hash_core.sv @@
module slhp_hash_core (
  input  logic                  clk,
  input  logic                  rst,
  input  slhp_pkg::hcore_cmd_t  cmd,
  output slhp_pkg::hcore_stat_t stat
);

  localparam logic [2:0] STEP_TAIL = 3'd3;

  logic [slhp_pkg::HASH_W-1:0] running_hash;
  logic [slhp_pkg::HASH_W-1:0] lane [4];
  logic [slhp_pkg::HASH_W-1:0] pend [3];
  logic [1:0]                  pend_cnt;
  logic                        full_seen;
  logic                        in_run;
  logic                        fin_active;
  logic [2:0]                  step;

  logic [1:0]                  pc_eff;
  logic                        fs_eff;
  logic                        group;
  logic [slhp_pkg::HASH_W-1:0] base [4];
  logic [2:0]                  tail_idx;
  logic [1:0]                  tail_sel;
  logic                        fin_done;
  logic [slhp_pkg::HASH_W-1:0] fin_a;
  logic [slhp_pkg::HASH_W-1:0] fin_b;

  // a word that opens a run sees empty run state
  always_comb begin
    pc_eff = in_run ? pend_cnt : 2'd0;
    fs_eff = in_run & full_seen;
    group  = (pc_eff == 2'd3);
    if (fs_eff) begin
      for (int k = 0; k < 4; k++) begin
        base[k] = lane[k];
      end
    end else begin
      base[0] = running_hash;
      base[1] = '0;
      base[2] = '0;
      base[3] = '0;
    end
  end

  // finish sequencer: three lane combines if a full group was seen, then the tail words
  always_comb begin
    tail_idx = step - STEP_TAIL;
    tail_sel = (tail_idx[1:0] == 2'd3) ? 2'd0 : tail_idx[1:0];
    fin_done = (step >= STEP_TAIL) && (tail_idx == {1'b0, pend_cnt});
    fin_a    = running_hash;
    fin_b    = pend[tail_sel];
    unique case (step)
      3'd0: begin
        fin_a = lane[0];
        fin_b = lane[1];
      end
      3'd1: fin_b = lane[2];
      3'd2: fin_b = lane[3];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      pend_cnt     <= '0;
      full_seen    <= 1'b0;
      in_run       <= 1'b0;
      fin_active   <= 1'b0;
      step         <= '0;
    end else begin
      if (cmd.clear) begin
        running_hash <= '0;
      end
      if (cmd.take) begin
        in_run    <= 1'b1;
        pend_cnt  <= group ? 2'd0 : pc_eff + 2'd1;
        full_seen <= group | fs_eff;
      end
      if (cmd.fin_go) begin
        if (in_run) begin
          fin_active <= 1'b1;
          step       <= full_seen ? 3'd0 : STEP_TAIL;
        end
      end else if (fin_active) begin
        if (fin_done) begin
          fin_active <= 1'b0;
          in_run     <= 1'b0;
          full_seen  <= 1'b0;
          pend_cnt   <= '0;
        end else begin
          running_hash <= slhp_pkg::mac131(fin_a, fin_b);
          step         <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (group) begin
        for (int k = 0; k < 3; k++) begin
          lane[k] <= slhp_pkg::mac131(base[k], pend[k]);
        end
        lane[3] <= slhp_pkg::mac131(base[3], cmd.word);
      end else begin
        pend[pc_eff] <= cmd.word;
      end
    end
  end

  assign stat.fin_busy = fin_active;
  assign stat.hash     = running_hash;

endmodule

@@ rtl/skip_masked_lane_poly_hash_unit.sv @@
// channel   | direction | beat contents
// s_axis    | in        | tdata: range_start, range_end, data_word; tuser: func; tlast: last_word
// m_axis    | out       | tdata: hash (one beat per buffer, after its last word)
// cfg       | in        | cfg_wdata: mode, written when cfg_we is high
//
// a data word takes a skip map row read, then a hash update; a run end adds the finish
// go and wait states plus one step per lane combine and tail word (up to 6)
// a last word adds an emit step; a range beat reads and writes back each skip map row
// after reset the skip map is zeroed one row per cycle, all 512 rows, with s_tready low
// s_tready is high only between items; m_axis has an output register, so a new item is
// taken while a hash waits, and only the emit step stalls on m_tready
module skip_masked_lane_poly_hash_unit (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // range_start[15:0], range_end[31:16], data_word[63:32]
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // last_word
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hash[31:0]
);

  localparam logic [2:0] T_IDLE     = 3'd0;
  localparam logic [2:0] T_LOOK     = 3'd1;
  localparam logic [2:0] T_FIN_GO   = 3'd2;
  localparam logic [2:0] T_FIN_WAIT = 3'd3;
  localparam logic [2:0] T_EMIT     = 3'd4;

  localparam logic FUNC_RANGE = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  slhp_pkg::smap_cmd_t   smap_cmd;
  slhp_pkg::smap_stat_t  smap_stat;
  slhp_pkg::hcore_cmd_t  hcore_cmd;
  slhp_pkg::hcore_stat_t hcore_stat;

  logic [2:0]                  state;
  logic                        mode;
  logic [slhp_pkg::IDX_W-1:0]  word_index;
  logic [slhp_pkg::HASH_W-1:0] item_word;
  logic                        item_last;
  logic                        use_map;
  logic                        out_valid;
  logic [slhp_pkg::HASH_W-1:0] out_hash;

  logic [slhp_pkg::ADDR_W-1:0] range_start;
  logic [slhp_pkg::ADDR_W-1:0] range_end;
  logic [slhp_pkg::ADDR_W:0]   first_dw;   // first dword whose first byte is in range
  logic [slhp_pkg::ADDR_W-3:0] last_dw;
  logic                        range_ok;
  logic                        accept;
  logic                        skip;
  logic                        emit;

  assign range_start = s_tdata[15:0];
  assign range_end   = s_tdata[31:16];

  // round the start up to a dword boundary; the 16-bit byte space maps onto exactly
  // the segment, so only a rounded-up start can run past it, and range_ok rejects that
  assign first_dw = ({1'b0, range_start} + (slhp_pkg::ADDR_W+1)'(3)) >> 2;
  assign last_dw  = range_end[slhp_pkg::ADDR_W-1:2];
  assign range_ok = (range_start <= range_end) &&
                    (first_dw <= {3'b000, last_dw});

  assign s_tready = (state == T_IDLE) && !smap_stat.busy;
  assign accept   = s_tvalid && s_tready;

  // a word is skipped only in segment mode and when its map bit is set
  assign skip = use_map & smap_stat.skip_bit;
  assign emit = (state == T_EMIT) && (!out_valid || m_tready);

  always_comb begin
    smap_cmd.mark_go    = accept && (s_tuser == FUNC_RANGE) && range_ok;
    smap_cmd.mark_first = first_dw[slhp_pkg::IDX_W-1:0];
    smap_cmd.mark_last  = last_dw[slhp_pkg::IDX_W-1:0];
    smap_cmd.look_go    = accept && (s_tuser == FUNC_DATA);
    smap_cmd.look_idx   = word_index;

    hcore_cmd.take   = (state == T_LOOK) && !skip;
    hcore_cmd.word   = item_word;
    hcore_cmd.fin_go = (state == T_FIN_GO);
    hcore_cmd.clear  = emit;
  end

  slhp_skip_map u_skip_map (
    .clk  (clk),
    .rst  (rst),
    .cmd  (smap_cmd),
    .stat (smap_stat)
  );

  slhp_hash_core u_hash_core (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hcore_cmd),
    .stat (hcore_stat)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      mode       <= 1'b0;
      word_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      unique case (state)
        T_IDLE: begin
          if (accept && (s_tuser == FUNC_DATA)) begin
            state <= T_LOOK;
          end
        end
        T_LOOK: begin
          // a last word rewinds the segment position
          word_index <= item_last ? '0 : word_index + 1'b1;
          if (skip || item_last) begin
            state <= T_FIN_GO;
          end else begin
            state <= T_IDLE;
          end
        end
        T_FIN_GO: begin
          state <= T_FIN_WAIT;
        end
        T_FIN_WAIT: begin
          if (!hcore_stat.fin_busy) begin
            state <= item_last ? T_EMIT : T_IDLE;
          end
        end
        T_EMIT: begin
          if (emit) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
      // output register: load wins over drain
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == FUNC_DATA)) begin
      item_word <= s_tdata[63:32];
      item_last <= s_tlast;
      use_map   <= ~mode;
    end
    if (emit) begin
      out_hash <= hcore_stat.hash;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_hash;

endmodule

@@ verif/skip_masked_lane_poly_hash_unit_tb.sv @@
module skip_masked_lane_poly_hash_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [slhp_pkg::ADDR_W-1:0] addr_t;
  typedef logic [slhp_pkg::HASH_W-1:0] hword_t;

  // beat kinds carried on s_tuser
  typedef enum logic {
    FN_RANGE = 1'b0,
    FN_WORD  = 1'b1
  } fn_t;

  // values of the mode register
  typedef enum logic {
    MODE_SEGMENT = 1'b0,
    MODE_PLAIN   = 1'b1
  } mode_t;

  typedef struct packed {
    fn_t    func;
    addr_t  rs;
    addr_t  re;
    hword_t word;
    logic   last;
  } beat_t;

  // one row of the directed table; typed marks a hash written in by hand
  typedef struct packed {
    beat_t  beat;
    logic   typed;
    hword_t hash;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 5000000;
  // longest busy stretch: a range beat over all 512 skip map rows
  localparam int DRAIN_CYCLES = 1100;
  localparam int DIR_ROWS = 28;

  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    // single words right after reset: the hash is the word itself
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h00000000, 1'b1}, 1'b1, 32'h00000000},
    '{'{FN_WORD,  16'hffff, 16'hffff, 32'hffffffff, 1'b1}, 1'b1, 32'hffffffff},
    // five words: one full lane group plus a one-word tail
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h89abcdef, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h01234567, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'hdeadbeef, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h0badf00d, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'hcafe1234, 1'b1}, 1'b0, 32'h0},
    // empty range, start above end
    '{'{FN_RANGE, 16'hffff, 16'h0000, 32'h5a5a5a5a, 1'b0}, 1'b0, 32'h0},
    // top byte only: no dword starts inside it
    '{'{FN_RANGE, 16'hffff, 16'hffff, 32'ha5a5a5a5, 1'b1}, 1'b0, 32'h0},
    // last dword of the segment
    '{'{FN_RANGE, 16'hfffc, 16'hffff, 32'h00000000, 1'b0}, 1'b0, 32'h0},
    // bytes inside dword 0 but not its first byte
    '{'{FN_RANGE, 16'h0001, 16'h0003, 32'h00000000, 1'b0}, 1'b0, 32'h0},
    // skip dword 2
    '{'{FN_RANGE, 16'h0008, 16'h000b, 32'h00000000, 1'b0}, 1'b0, 32'h0},
    // six words: run of two, skipped word, run of three
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h11111111, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h22222222, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h33333333, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h44444444, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h55555555, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h66666666, 1'b1}, 1'b0, 32'h0},
    // open a stream, then mark dwords 5 and 6 while it runs
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000001, 1'b0}, 1'b0, 32'h0},
    '{'{FN_RANGE, 16'h0014, 16'h001b, 32'h00000000, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000002, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000003, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000004, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000005, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000006, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h80000007, 1'b1}, 1'b0, 32'h0},
    // skip dword 0, then a lone word that falls on it: nothing hashed
    '{'{FN_RANGE, 16'h0000, 16'h0000, 32'h00000000, 1'b0}, 1'b0, 32'h0},
    '{'{FN_WORD,  16'h0000, 16'h0000, 32'h13579bdf, 1'b1}, 1'b1, 32'h00000000}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // range_start[15:0], range_end[31:16], data_word[63:32]
  logic        s_tuser = 1'b0; // func
  logic        s_tlast = 1'b0; // last_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // hash[31:0]

  skip_masked_lane_poly_hash_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // hash predictor state
  logic   map_bits [slhp_pkg::SEG_WORDS];
  mode_t  cur_mode;
  hword_t chain_hash;
  hword_t lane [4];
  hword_t tail_w [3];
  int     tail_n;
  logic   group_seen;
  logic   run_open;
  int     word_pos;

  hword_t hash_due_q [$];   // hashes still owed by the block
  int     err_count = 0;
  int     cycle_count;
  int     src_idle_pct = 0;
  int     rcv_stall_pct = 0;

  function automatic hword_t fold131(input hword_t h, input hword_t w);
    return h * 32'd131 + w;
  endfunction

  // close the open run: combine lanes if a full group went by, then fold the tail
  task automatic close_run();
    hword_t h;
    h = chain_hash;
    if (run_open) begin
      if (group_seen) begin
        h = fold131(lane[0], lane[1]);
        h = fold131(h, lane[2]);
        h = fold131(h, lane[3]);
      end
      for (int k = 0; k < tail_n; k++) h = fold131(h, tail_w[k]);
      chain_hash = h;
      run_open   = 1'b0;
      group_seen = 1'b0;
      tail_n     = 0;
    end
  endtask

  task automatic absorb_word(input hword_t w);
    if (!run_open) begin
      run_open   = 1'b1;
      group_seen = 1'b0;
      tail_n     = 0;
    end
    if (tail_n < 3) begin
      tail_w[tail_n] = w;
      tail_n++;
    end else begin
      // first full group seeds lane 0 with the hash carried in
      if (!group_seen) begin
        lane[0] = chain_hash;
        lane[1] = '0;
        lane[2] = '0;
        lane[3] = '0;
        group_seen = 1'b1;
      end
      for (int k = 0; k < 3; k++) lane[k] = fold131(lane[k], tail_w[k]);
      lane[3] = fold131(lane[3], w);
      tail_n = 0;
    end
  endtask

  // advance the predictor by one accepted beat
  task automatic predict_beat(input beat_t b, output logic emits, output hword_t h);
    int d;
    int d_end;
    emits = 1'b0;
    h = '0;
    if (b.func == FN_RANGE) begin
      // dwords whose first byte falls in the range, clipped to the segment
      if (b.rs <= b.re) begin
        d = (int'(b.rs) + 3) >> 2;
        d_end = int'(b.re) >> 2;
        for (; d <= d_end && d < slhp_pkg::SEG_WORDS; d++) map_bits[d] = 1'b1;
      end
    end else begin
      if (cur_mode == MODE_SEGMENT && map_bits[word_pos]) close_run();
      else absorb_word(b.word);
      word_pos = (word_pos + 1) % slhp_pkg::SEG_WORDS;
      if (b.last) begin
        close_run();
        emits = 1'b1;
        h = chain_hash;
        chain_hash = '0;
        word_pos = 0;
      end
    end
  endtask

  // present one beat, hold it until taken, then book its hash if it ends a buffer
  task automatic send_beat(input beat_t b, input logic typed, input hword_t hand);
    logic   emits;
    hword_t h;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.word, b.re, b.rs};
    s_tuser  <= b.func;
    s_tlast  <= b.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_beat(b, emits, h);
    if (emits) hash_due_q.push_back(typed ? hand : h);
  endtask

  // mostly narrow ranges over the low dwords that buffers actually reach
  function automatic beat_t make_range();
    beat_t b;
    b.func = FN_RANGE;
    b.word = $urandom();
    b.last = 1'($urandom_range(1));
    if ($urandom_range(99) < 70) begin
      b.rs = addr_t'($urandom_range(511));
      b.re = addr_t'(b.rs + $urandom_range(11));
    end else begin
      b.rs = addr_t'($urandom_range(65535));
      b.re = addr_t'($urandom_range(65535));
    end
    return b;
  endfunction

  function automatic beat_t make_word(input logic last);
    beat_t b;
    b.func = FN_WORD;
    b.rs   = addr_t'($urandom_range(65535));
    b.re   = addr_t'($urandom_range(65535));
    b.word = $urandom();
    b.last = last;
    return b;
  endfunction

  // random buffers with ranges slipped in; a burst may stop inside a buffer
  task automatic random_burst(input int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 8) begin
        send_beat(make_range(), 1'b0, '0);
        left--;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len && left > 0; i++) begin
          if ($urandom_range(99) < 6) begin
            send_beat(make_range(), 1'b0, '0);
            left--;
          end
          send_beat(make_word(i == len - 1), 1'b0, '0);
          left--;
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // mode is only written once the block has drained
  task automatic write_mode(input mode_t m);
    while (hash_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("skip_masked_lane_poly_hash_unit test failed");
    $finish;
  end

  // result side: check each taken beat, then pick next cycle's ready
  initial begin
    hword_t due;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (hash_due_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected hash beat %h", m_tdata);
        end else begin
          due = hash_due_q.pop_front();
          if (m_tdata !== due) begin
            err_count++;
            if (err_count <= 10) $display("hash mismatch: expected %h got %h", due, m_tdata);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < slhp_pkg::SEG_WORDS; i++) map_bits[i] = 1'b0;
    for (int k = 0; k < 4; k++) lane[k] = '0;
    for (int k = 0; k < 3; k++) tail_w[k] = '0;
    cur_mode   = MODE_SEGMENT;
    chain_hash = '0;
    tail_n     = 0;
    group_seen = 1'b0;
    run_open   = 1'b0;
    word_pos   = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // skip map clearing pass holds s_tready low
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    // segment mode, no idling: directed table, then random beats
    write_mode(MODE_SEGMENT);
    for (int r = 0; r < DIR_ROWS; r++)
      send_beat(DIR_TAB[r].beat, DIR_TAB[r].typed, DIR_TAB[r].hash);
    random_burst(80);

    // plain mode with a sparse sender; any open buffer carries across the switch
    write_mode(MODE_PLAIN);
    src_idle_pct  = 79;
    rcv_stall_pct = 0;
    random_burst(80);

    // segment mode against a stalling receiver
    write_mode(MODE_SEGMENT);
    src_idle_pct  = 0;
    rcv_stall_pct = 79;
    random_burst(80);

    // plain mode, light idling on both sides
    write_mode(MODE_PLAIN);
    src_idle_pct  = 18;
    rcv_stall_pct = 18;
    random_burst(80);

    // back to segment mode, no idling, closing any open buffer at the end
    write_mode(MODE_SEGMENT);
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    random_burst(50);
    @(posedge clk);
    send_beat(make_word(1'b1), 1'b0, '0);
    s_tvalid <= 1'b0;

    while (hash_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("skip_masked_lane_poly_hash_unit test passed");
    end else begin
      $display("skip_masked_lane_poly_hash_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/slhp_pkg.sv
rtl/slhp_skip_map.sv
rtl/slhp_hash_core.sv
rtl/skip_masked_lane_poly_hash_unit.sv
verif/skip_masked_lane_poly_hash_unit_tb.sv
